/* rtl/v2cm_pkg.sv */
package v2cm_pkg;

  // configuration port geometry
  localparam int ADDR_W   = 5;
  localparam int COUNT_W  = 11;
  localparam int SCHEME_W = 3;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_RANGE_LOW   = 3'd0,
    REG_RANGE_HIGH  = 3'd1,
    REG_COLOR_COUNT = 3'd2,
    REG_SCHEME      = 3'd3,
    REG_INVERT      = 3'd4
  } reg_idx_e;

  // reset values
  localparam logic [31:0]         RST_RANGE_LOW   = 32'h0000_0000;
  localparam logic [31:0]         RST_RANGE_HIGH  = 32'h0001_0000;
  localparam logic [COUNT_W-1:0]  RST_COLOR_COUNT = 11'd2;

  // ramp codes
  localparam logic [SCHEME_W-1:0] SCH_MONO    = 3'd0;
  localparam logic [SCHEME_W-1:0] SCH_GRAY    = 3'd1;
  localparam logic [SCHEME_W-1:0] SCH_RAINBOW = 3'd2;
  localparam logic [SCHEME_W-1:0] SCH_HOT     = 3'd3;
  localparam logic [SCHEME_W-1:0] SCH_BLEND   = 3'd4;

  // per channel result kind
  typedef enum logic [1:0] {
    CH_ZERO,
    CH_FULL,
    CH_DIV
  } ch_mode_e;

  // blend ramp, Q0.16 start levels and signed Q1.16 segment slopes (red, green, blue)
  localparam logic [15:0] BL_A0 [3] = '{16'd23128, 16'd24415, 16'd22102};
  localparam logic [15:0] BL_A1 [3] = '{16'd58339, 16'd1542, 16'd4883};
  localparam logic signed [17:0] BL_D0 [3] = '{18'sd35211, -18'sd22873, -18'sd17219};
  localparam logic signed [17:0] BL_D1 [3] = '{18'sd3920, 18'sd60717, 18'sd57376};

  // x / 100 for any 32-bit unsigned x
  localparam logic [31:0] DIV100_MUL   = 32'h51EB_851F;
  localparam int          DIV100_SHIFT = 37;

endpackage

/* rtl/value_to_colormap_rgb.sv */
// Spectrogram colormap lookup: one signed Q15.16 sample in, one packed RGB
// colour and its palette index out.
// Input channel: sample_i with sample_valid_i / sample_ready_o.
// Output channel: rgb_o and color_index_o with result_valid_o / result_ready_i.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12, 16
// (range_low, range_high, color_count, scheme, invert); pready is tied high.
// Write configuration only while no sample is in flight.
// Throughput: one sample per clock while the output skid register is empty.
// Pipeline: the index division retires one quotient bit per stage and the
// channel division takes eight more stages.
// Range limits pass through three register stages that trail each write, and the
// colour count through its own registers, before any sample reaches them.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, a one-beat skid register keeps the result and the
// pipeline still takes one more beat, then holds until the skid drains.
module value_to_colormap_rgb #(
  parameter int MAX_COLORS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [v2cm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic signed [31:0]            sample_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [23:0]                   rgb_o,
  output logic [$clog2(MAX_COLORS)-1:0] color_index_o
);
  import v2cm_pkg::*;

  localparam int KW   = $clog2(MAX_COLORS);
  localparam int NW   = $clog2(MAX_COLORS + 1);
  localparam int RW   = 33;
  localparam int PW   = RW + KW;
  localparam int TW   = KW + 18;
  localparam int DW   = KW + 16;
  localparam int UW   = TW + 8;
  localparam int CB   = 8;
  localparam int NCH  = 3;
  localparam int NSTG = KW + 17;

  // configuration registers
  logic signed [31:0]  range_low_q, range_high_q;
  logic [COUNT_W-1:0]  color_count_q;
  logic [SCHEME_W-1:0] scheme_q;
  logic                invert_q;
  logic                wr_en;
  reg_idx_e            reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q   <= RST_RANGE_LOW;
      range_high_q  <= RST_RANGE_HIGH;
      color_count_q <= RST_COLOR_COUNT;
      scheme_q      <= SCH_MONO;
      invert_q      <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RANGE_LOW:   range_low_q   <= pwdata;
        REG_RANGE_HIGH:  range_high_q  <= pwdata;
        REG_COLOR_COUNT: color_count_q <= pwdata[COUNT_W-1:0];
        REG_SCHEME:      scheme_q      <= pwdata[SCHEME_W-1:0];
        REG_INVERT:      invert_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_RANGE_LOW:   prdata = range_low_q;
      REG_RANGE_HIGH:  prdata = range_high_q;
      REG_COLOR_COUNT: prdata = 32'(color_count_q);
      REG_SCHEME:      prdata = 32'(scheme_q);
      REG_INVERT:      prdata = 32'(invert_q);
      default:         prdata = '0;
    endcase
  end

  // config conditioning, first stage: order limits, saturate count
  logic signed [31:0] lo1_d, hi1_d, lo1_q, hi1_q;
  logic               eq1_q;
  logic [31:0]        ahi1_d, ahi1_q;
  logic [31:0]        cc32, nsat32;
  logic [NW-1:0]      n_d, n_q, half_q, e1_q, e3_q, e5_q, e6_q, e7_q;
  logic [NW+2:0]      n3x, n5x, n7x;
  logic [DW-1:0]      den_n_q, den2n_q, den3n_q, denm_q;

  always_comb begin
    lo1_d  = (range_low_q > range_high_q) ? range_high_q : range_low_q;
    hi1_d  = (range_low_q > range_high_q) ? range_low_q : range_high_q;
    ahi1_d = hi1_d[31] ? (~hi1_d + 32'd1) : hi1_d;
    cc32   = 32'(color_count_q);
    if (cc32 < 32'd2) begin
      nsat32 = 32'd2;
    end else if (cc32 > 32'(MAX_COLORS)) begin
      nsat32 = 32'(MAX_COLORS);
    end else begin
      nsat32 = cc32;
    end
    n_d = NW'(nsat32);
    n3x = (NW+3)'(n_d) + ((NW+3)'(n_d) << 1);
    n5x = (NW+3)'(n_d) + ((NW+3)'(n_d) << 2);
    n7x = ((NW+3)'(n_d) << 3) - (NW+3)'(n_d);
  end

  always_ff @(posedge clk_i) begin
    lo1_q   <= lo1_d;
    hi1_q   <= hi1_d;
    eq1_q   <= (range_low_q == range_high_q);
    ahi1_q  <= ahi1_d;
    n_q     <= n_d;
    half_q  <= n_d >> 1;
    e1_q    <= n_d >> 3;
    e3_q    <= NW'(n3x >> 3);
    e5_q    <= NW'(n5x >> 3);
    e6_q    <= NW'(n3x >> 2);
    e7_q    <= NW'(n7x >> 3);
    den_n_q <= DW'(n_d);
    den2n_q <= DW'(n_d) << 1;
    den3n_q <= DW'(n3x);
    denm_q  <= DW'(n_d >> 1) << 16;
  end

  // second stage: one percent of |high|, blend offsets
  logic [63:0]              div100_prod;
  logic [63-DIV100_SHIFT:0] q100_q;
  logic signed [31:0]       lo2_q, hi2_q;
  logic                     eq2_q;
  logic signed [TW-1:0]     am0_q [NCH];
  logic signed [TW-1:0]     am1_q [NCH];

  assign div100_prod = 64'(ahi1_q) * 64'(DIV100_MUL);

  always_ff @(posedge clk_i) begin
    q100_q <= div100_prod[63:DIV100_SHIFT];
    lo2_q  <= lo1_q;
    hi2_q  <= hi1_q;
    eq2_q  <= eq1_q;
    for (int c = 0; c < NCH; c++) begin
      am0_q[c] <= $signed(TW'(32'(BL_A0[c]) * 32'(half_q)));
      am1_q[c] <= $signed(TW'(32'(BL_A1[c]) * 32'(half_q)));
    end
  end

  // third stage: final limits and span
  logic signed [RW-1:0] hi33, lo_eq, lo_f_d, lo_f_q, hi_f_q;
  logic [RW-1:0]        rng_q;

  always_comb begin
    hi33   = RW'(hi2_q);
    lo_eq  = (q100_q == '0) ? (hi33 - RW'(1)) : (hi33 - $signed(RW'(q100_q)));
    lo_f_d = eq2_q ? lo_eq : RW'(lo2_q);
  end

  always_ff @(posedge clk_i) begin
    lo_f_q <= lo_f_d;
    hi_f_q <= hi33;
    rng_q  <= hi33 - lo_f_d;
  end

  // pipeline control: every stage moves while the skid is empty
  logic            en;
  logic            skid_vld_q;
  logic [NSTG-1:0] vld_q;

  assign en             = !skid_vld_q;
  assign sample_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], sample_valid_i};
    end
  end

  // sample delay while limits settle
  logic signed [31:0] v_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q[0] <= sample_i;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
    end
  end

  // clamp against the limits
  logic signed [RW:0] v34, diff34;
  logic               blw_d, abv_d, blw_r_q, abv_r_q;
  logic [RW-1:0]      diff_q;

  always_comb begin
    v34    = (RW+1)'(v_q[2]);
    blw_d  = v34 < (RW+1)'(lo_f_q);
    abv_d  = v34 >= (RW+1)'(hi_f_q);
    diff34 = v34 - (RW+1)'(lo_f_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      blw_r_q <= blw_d;
      abv_r_q <= abv_d;
      diff_q  <= (blw_d || abv_d) ? '0 : diff34[RW-1:0];
    end
  end

  // scale by colour count
  logic [RW+NW-1:0] prod_full;
  logic [PW-1:0]    prod_q;
  logic             blw_p_q, abv_p_q;

  assign prod_full = (RW+NW)'(diff_q) * (RW+NW)'(n_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= prod_full[PW-1:0];
      blw_p_q <= blw_r_q;
      abv_p_q <= abv_r_q;
    end
  end

  // index division by span, one quotient bit per stage
  logic [PW-1:0] drem_q [KW];
  logic [KW-1:0] dquo_q [KW];
  logic          dblw_q [KW];
  logic          dabv_q [KW];

  for (genvar j = 0; j < KW; j++) begin : g_idiv
    localparam int B = KW - 1 - j;
    logic [PW-1:0] rin;
    logic [KW-1:0] qin;
    logic          bin, ain;
    logic [PW:0]   sub;

    if (j == 0) begin : g_first
      assign rin = prod_q;
      assign qin = '0;
      assign bin = blw_p_q;
      assign ain = abv_p_q;
    end else begin : g_next
      assign rin = drem_q[j-1];
      assign qin = dquo_q[j-1];
      assign bin = dblw_q[j-1];
      assign ain = dabv_q[j-1];
    end

    assign sub = {1'b0, rin} - ((PW+1)'(rng_q) << B);

    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[j] <= sub[PW] ? rin : sub[PW-1:0];
        dquo_q[j] <= sub[PW] ? qin : (qin | (KW'(1) << B));
        dblw_q[j] <= bin;
        dabv_q[j] <= ain;
      end
    end
  end

  // palette index and ramp position
  logic [NW-1:0] nm1, qn, idx_n, k_n;
  logic [KW-1:0] idx_q, k_q;

  always_comb begin
    nm1 = n_q - NW'(1);
    qn  = NW'(dquo_q[KW-1]);
    if (dblw_q[KW-1]) begin
      idx_n = '0;
    end else if (dabv_q[KW-1] || (qn > nm1)) begin
      idx_n = nm1;
    end else begin
      idx_n = qn;
    end
    k_n = invert_q ? (nm1 - idx_n) : idx_n;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q <= KW'(idx_n);
      k_q   <= KW'(k_n);
    end
  end

  // ramp segment: per channel kind, ratio term and divisor
  ch_mode_e             md [NCH];
  logic signed [TW-1:0] tt [NCH];
  logic [DW-1:0]        dd [NCH];
  ch_mode_e             sm_q [NCH];
  logic signed [TW-1:0] st_q [NCH];
  logic [DW-1:0]        sd_q [NCH];
  logic [KW-1:0]        sidx_q;

  always_comb begin
    logic [NW-1:0]        kn;
    logic signed [TW-1:0] ks, ns, hs, e1s, e3s, e5s, e6s, e7s, kds;
    kn  = NW'(k_q);
    ks  = $signed(TW'(k_q));
    ns  = $signed(TW'(n_q));
    hs  = $signed(TW'(half_q));
    e1s = $signed(TW'(e1_q));
    e3s = $signed(TW'(e3_q));
    e5s = $signed(TW'(e5_q));
    e6s = $signed(TW'(e6_q));
    e7s = $signed(TW'(e7_q));
    kds = (kn < half_q) ? ks : (ks - hs);
    for (int c = 0; c < NCH; c++) begin
      md[c] = CH_ZERO;
      tt[c] = '0;
      dd[c] = den_n_q;
    end
    case (scheme_q)
      SCH_MONO: begin
        if (kn > half_q) begin
          for (int c = 0; c < NCH; c++) md[c] = CH_FULL;
        end
      end
      SCH_GRAY: begin
        for (int c = 0; c < NCH; c++) begin
          md[c] = CH_DIV;
          tt[c] = ks;
        end
      end
      SCH_RAINBOW: begin
        if (kn < e1_q) begin
          md[2] = CH_DIV;
          tt[2] = (ks <<< 3) + ns;
          dd[2] = den2n_q;
        end else if (kn < e3_q) begin
          md[1] = CH_DIV;
          tt[1] = (ks - e1s) <<< 2;
          md[2] = CH_FULL;
        end else if (kn < e5_q) begin
          md[0] = CH_DIV;
          tt[0] = (ks - e3s) <<< 2;
          md[1] = CH_FULL;
          md[2] = CH_DIV;
          tt[2] = ns - ((ks - e3s) <<< 2);
        end else if (kn < e7_q) begin
          md[0] = CH_FULL;
          md[1] = CH_DIV;
          tt[1] = ns - ((ks - e5s) <<< 2);
        end else begin
          md[0] = CH_DIV;
          tt[0] = ns - ((ks - e7s) <<< 2);
        end
      end
      SCH_HOT: begin
        if (kn < e3_q) begin
          md[0] = CH_DIV;
          tt[0] = ks <<< 3;
          dd[0] = den3n_q;
        end else if (kn < e6_q) begin
          md[0] = CH_FULL;
          md[1] = CH_DIV;
          tt[1] = (ks - e3s) <<< 3;
          dd[1] = den3n_q;
        end else begin
          md[0] = CH_FULL;
          md[1] = CH_FULL;
          md[2] = CH_DIV;
          tt[2] = (ks - e6s) <<< 2;
        end
      end
      SCH_BLEND: begin
        for (int c = 0; c < NCH; c++) begin
          md[c] = CH_DIV;
          dd[c] = denm_q;
          if (kn < half_q) begin
            tt[c] = am0_q[c] + (TW'(BL_D0[c]) * kds);
          end else begin
            tt[c] = am1_q[c] + (TW'(BL_D1[c]) * kds);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q   <= md;
      st_q   <= tt;
      sd_q   <= dd;
      sidx_q <= idx_q;
    end
  end

  // channel numerator 255*t, zero and saturation checks
  logic signed [UW-1:0] numv [NCH];
  ch_mode_e             nmd  [NCH];
  logic [UW-1:0]        num_q [NCH];
  logic [DW-1:0]        nd_q  [NCH];
  ch_mode_e             nm_q  [NCH];
  logic [KW-1:0]        nidx_q;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      numv[c] = (UW'(st_q[c]) <<< 8) - UW'(st_q[c]);
      nmd[c]  = sm_q[c];
      if (sm_q[c] == CH_DIV) begin
        if (st_q[c] <= 0) begin
          nmd[c] = CH_ZERO;
        end else if (UW'(numv[c]) >= (UW'(sd_q[c]) << 8)) begin
          nmd[c] = CH_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NCH; c++) begin
        num_q[c] <= UW'(numv[c]);
        nd_q[c]  <= sd_q[c];
        nm_q[c]  <= nmd[c];
      end
      nidx_q <= sidx_q;
    end
  end

  // channel division, one quotient bit per stage
  logic [UW-1:0] crem_q [CB][NCH];
  logic [CB-1:0] cquo_q [CB][NCH];
  logic [DW-1:0] cden_q [CB][NCH];
  ch_mode_e      cmd_q  [CB][NCH];
  logic [KW-1:0] cidx_q [CB];

  for (genvar j = 0; j < CB; j++) begin : g_cdiv
    localparam int B = CB - 1 - j;
    logic [UW-1:0] rin [NCH];
    logic [CB-1:0] qin [NCH];
    logic [DW-1:0] din [NCH];
    ch_mode_e      min [NCH];
    logic [KW-1:0] iin;
    logic [UW:0]   sub [NCH];

    if (j == 0) begin : g_first
      assign rin = num_q;
      assign qin = '{default: '0};
      assign din = nd_q;
      assign min = nm_q;
      assign iin = nidx_q;
    end else begin : g_next
      assign rin = crem_q[j-1];
      assign qin = cquo_q[j-1];
      assign din = cden_q[j-1];
      assign min = cmd_q[j-1];
      assign iin = cidx_q[j-1];
    end

    for (genvar c = 0; c < NCH; c++) begin : g_ch
      assign sub[c] = {1'b0, rin[c]} - ((UW+1)'(din[c]) << B);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < NCH; c++) begin
          crem_q[j][c] <= sub[c][UW] ? rin[c] : sub[c][UW-1:0];
          cquo_q[j][c] <= sub[c][UW] ? qin[c] : (qin[c] | (CB'(1) << B));
          cden_q[j][c] <= din[c];
          cmd_q[j][c]  <= min[c];
        end
        cidx_q[j] <= iin;
      end
    end
  end

  // pack the colour
  logic [7:0]    chv [NCH];
  logic [23:0]   rgb_q, skid_rgb_q;
  logic [KW-1:0] oidx_q, skid_idx_q;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      case (cmd_q[CB-1][c])
        CH_FULL: chv[c] = 8'hFF;
        CH_DIV:  chv[c] = cquo_q[CB-1][c];
        default: chv[c] = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rgb_q  <= {chv[0], chv[1], chv[2]};
      oidx_q <= cidx_q[CB-1];
    end
  end

  // output skid, holds one beat while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q && result_ready_i) begin
      skid_vld_q <= 1'b0;
    end else if (!skid_vld_q && vld_q[NSTG-1] && !result_ready_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_rgb_q <= rgb_q;
      skid_idx_q <= oidx_q;
    end
  end

  assign result_valid_o = skid_vld_q | vld_q[NSTG-1];
  assign rgb_o          = skid_vld_q ? skid_rgb_q : rgb_q;
  assign color_index_o  = skid_vld_q ? skid_idx_q : oidx_q;

  // index never leaves the palette in use
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (32'(color_index_o) < 32'(n_q)))
    else $error("color index beyond colour count");

  // mono gives only black or white
  a_mono_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (scheme_q == SCH_MONO))
      |-> ((rgb_o == 24'h000000) || (rgb_o == 24'hFFFFFF)))
    else $error("mono result not black or white");

  // gray keeps all channels equal
  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (scheme_q == SCH_GRAY))
      |-> ((rgb_o[23:16] == rgb_o[15:8]) && (rgb_o[15:8] == rgb_o[7:0])))
    else $error("gray result channels differ");

  // a stalled beat is held until taken
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_ready_i) |=> (result_valid_o && $stable(rgb_o)
      && $stable(color_index_o)))
    else $error("stalled result changed");

endmodule
